>>> src/crtg_pkg.sv
// ----------------------------------------------------------------------------
// Cadenced ring tone generator package
// Shared constants, register indexes and the control structures passed
// between the sequencer and the serial multiplier.
// ----------------------------------------------------------------------------
package crtg_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP   = 3'd4;

    // Register and field widths.
    localparam int PHASE_W  = 32;
    localparam int LEN_W    = 24;
    localparam int AMP_W    = 16;
    localparam int FADE_W   = 25;
    localparam int SAMPLE_W = 16;
    localparam int ROM_W    = 15;

    // Register values after reset.
    localparam logic [PHASE_W-1:0] PHASE_STEP_RST  = 32'd38028356;
    localparam logic [LEN_W-1:0]   TONE_LENGTH_RST = 24'd48000;
    localparam logic [LEN_W-1:0]   CYCLE_LEN_RST   = 24'd240000;
    localparam logic [AMP_W-1:0]   AMPLITUDE_RST   = 16'd14418;
    localparam logic [FADE_W-1:0]  FADE_STEP_RST   = 25'd34953;

    // Unity fade gain in Q1.24.
    localparam logic [FADE_W-1:0] FADE_ONE = 25'h100_0000;

    // Sine series constants in Q30.
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SINE_AMP    = 64'd32767;
    localparam logic [63:0] Q30_HALF    = 64'd536870912;
    localparam logic [63:0] DIV_1       = 64'd156;
    localparam logic [63:0] DIV_2       = 64'd110;
    localparam logic [63:0] DIV_3       = 64'd72;
    localparam logic [63:0] DIV_4       = 64'd42;
    localparam logic [63:0] DIV_5       = 64'd20;
    localparam logic [63:0] DIV_6       = 64'd6;

    // Serial multiplier geometry: radix-4, two multiplier bits per step.
    localparam int MCAND_W  = 31;
    localparam int MPLIER_W = 26;
    localparam int STEP_W   = 4;
    localparam logic [STEP_W-1:0] STEPS_AMP  = 4'd8;
    localparam logic [STEP_W-1:0] STEPS_FADE = 4'd13;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } mul_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

>>> src/cadenced_ring_tone_generator.sv
// ----------------------------------------------------------------------------
// Cadenced ring tone generator
// One audio sample of a ring cadence for every sample tick transferred in.
// ----------------------------------------------------------------------------
// Usage. Each transfer on the s_ channel is one sample tick; s_tdata bit 0 is
// the restart flag, which starts a fresh cycle at position zero with phase
// and fade cleared. Each tick produces exactly one transfer on the m_
// channel: the signed sample in m_tdata, the tone flag in m_tuser and the
// last-sample-of-cycle flag in m_tlast. Registers are written through the
// cfg_ port at any rising edge with cfg_wr_en high; the user must write them
// only while idle, not enforced by the block; they apply from the next tick.
// Timing. A tick in the silent part of the cycle goes straight from acceptance
// to the output state. A tone tick goes through an index stage, a registered
// sine ROM read and two passes of the radix-4 serial multiplier (8 steps for
// the amplitude, 13 steps for the fade gain) before it reaches the output
// register. One tick is in flight at a time: the next tick is accepted only
// once the result has been loaded into the output register.
// Reset clears the position, phase and fade gain, restores all registers to
// their reset values and empties the output register. When the receiver
// stalls, the finished result waits in the output register while the next
// tick is accepted and computed; it then waits for the output to free up.
// ----------------------------------------------------------------------------
module cadenced_ring_tone_generator #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int COUNT_WIDTH      = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input channel: s_tdata = {7'b0, restart}
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    // Result channel: m_tdata = sample, m_tuser = tone_active,
    // m_tlast = cycle_end
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [crtg_pkg::SAMPLE_W-1:0]       m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [crtg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [crtg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
    localparam int EXT_W  = (COUNT_WIDTH > crtg_pkg::LEN_W) ? COUNT_WIDTH : crtg_pkg::LEN_W;
    localparam int IDX_PROD_W = 31 + ADDR_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_IDX   = 3'd1;
    localparam logic [2:0] ST_ROM   = 3'd2;
    localparam logic [2:0] ST_MA_GO = 3'd3;
    localparam logic [2:0] ST_MA    = 3'd4;
    localparam logic [2:0] ST_MB    = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // ------------------------------------------------------------------
    // Quarter-wave sine ROM. Entry k holds round(32767 * sin(pi/2 *
    // (k + 0.5) / depth)), worked out at elaboration with the same Q30
    // Horner series that defines the table, so every bit matches.
    // ------------------------------------------------------------------
    logic [crtg_pkg::ROM_W-1:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] X  = (crtg_pkg::HALF_PI_Q30 * 64'(2 * k + 1))
                                     / 64'(2 * SINE_TABLE_DEPTH);
        localparam logic [63:0] X2 = (X * X) >> 30;
        localparam logic [63:0] T1 = crtg_pkg::Q30_ONE
                                     - ((X2 * crtg_pkg::Q30_ONE) >> 30) / crtg_pkg::DIV_1;
        localparam logic [63:0] T2 = crtg_pkg::Q30_ONE - ((X2 * T1) >> 30) / crtg_pkg::DIV_2;
        localparam logic [63:0] T3 = crtg_pkg::Q30_ONE - ((X2 * T2) >> 30) / crtg_pkg::DIV_3;
        localparam logic [63:0] T4 = crtg_pkg::Q30_ONE - ((X2 * T3) >> 30) / crtg_pkg::DIV_4;
        localparam logic [63:0] T5 = crtg_pkg::Q30_ONE - ((X2 * T4) >> 30) / crtg_pkg::DIV_5;
        localparam logic [63:0] T6 = crtg_pkg::Q30_ONE - ((X2 * T5) >> 30) / crtg_pkg::DIV_6;
        localparam logic [63:0] S  = (X * T6) >> 30;
        localparam logic [63:0] ENTRY = (S * crtg_pkg::SINE_AMP + crtg_pkg::Q30_HALF) >> 30;
        assign sine_rom[k] = ENTRY[crtg_pkg::ROM_W-1:0];
    end

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [crtg_pkg::PHASE_W-1:0] phase_step_reg;
    logic [crtg_pkg::LEN_W-1:0]   tone_length_reg;
    logic [crtg_pkg::LEN_W-1:0]   cycle_length_reg;
    logic [crtg_pkg::AMP_W-1:0]   amplitude_reg;
    logic [crtg_pkg::FADE_W-1:0]  fade_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg   <= crtg_pkg::PHASE_STEP_RST;
            tone_length_reg  <= crtg_pkg::TONE_LENGTH_RST;
            cycle_length_reg <= crtg_pkg::CYCLE_LEN_RST;
            amplitude_reg    <= crtg_pkg::AMPLITUDE_RST;
            fade_step_reg    <= crtg_pkg::FADE_STEP_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                crtg_pkg::REG_PHASE_STEP:  phase_step_reg   <= cfg_wdata;
                crtg_pkg::REG_TONE_LENGTH: tone_length_reg  <= cfg_wdata[crtg_pkg::LEN_W-1:0];
                crtg_pkg::REG_CYCLE_LEN:   cycle_length_reg <= cfg_wdata[crtg_pkg::LEN_W-1:0];
                crtg_pkg::REG_AMPLITUDE:   amplitude_reg    <= cfg_wdata[crtg_pkg::AMP_W-1:0];
                crtg_pkg::REG_FADE_STEP:   fade_step_reg    <= cfg_wdata[crtg_pkg::FADE_W-1:0];
                default: begin
                    // Indexes beyond the register list are ignored.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Cadence state and the per-tick decisions, all taken in the cycle in
    // which the tick is accepted.
    // ------------------------------------------------------------------
    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic [COUNT_WIDTH-1:0]       position_reg;
    logic [crtg_pkg::PHASE_W-1:0] phase_reg;
    logic [crtg_pkg::FADE_W-1:0]  fade_gain_reg;

    logic                         s_fire;
    logic                         restart;
    logic [COUNT_WIDTH-1:0]       pos_eff;
    logic [crtg_pkg::PHASE_W-1:0] phase_eff;
    logic [crtg_pkg::FADE_W-1:0]  fade_eff;
    logic [EXT_W-1:0]             tone_ext;
    logic [EXT_W-1:0]             cycle_ext;
    logic [COUNT_WIDTH-1:0]       cycle_m1;
    logic                         tone_now;
    logic                         last_now;
    logic [crtg_pkg::PHASE_W-1:0] phase_adv;
    logic [crtg_pkg::FADE_W:0]    fade_sum;
    logic [crtg_pkg::FADE_W-1:0]  fade_adv;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign restart  = s_tdata[0];

    assign pos_eff   = restart ? '0 : position_reg;
    assign phase_eff = restart ? '0 : phase_reg;
    assign fade_eff  = restart ? '0 : fade_gain_reg;

    // Lengths are taken modulo the position counter's range; a cycle length
    // of zero thus wraps to a full counter range.
    assign tone_ext  = EXT_W'(tone_length_reg);
    assign cycle_ext = EXT_W'(cycle_length_reg);
    assign cycle_m1  = cycle_ext[COUNT_WIDTH-1:0] - COUNT_WIDTH'(1);
    assign tone_now  = pos_eff < tone_ext[COUNT_WIDTH-1:0];
    assign last_now  = pos_eff >= cycle_m1;

    assign phase_adv = phase_eff + phase_step_reg;
    assign fade_sum  = {1'b0, fade_eff} + {1'b0, fade_step_reg};
    assign fade_adv  = (fade_sum > {1'b0, crtg_pkg::FADE_ONE}) ? crtg_pkg::FADE_ONE
                                                               : fade_sum[crtg_pkg::FADE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg  <= '0;
            phase_reg     <= '0;
            fade_gain_reg <= '0;
        end else if (s_fire) begin
            if (last_now) begin
                position_reg  <= '0;
                phase_reg     <= '0;
                fade_gain_reg <= '0;
            end else begin
                position_reg  <= pos_eff + COUNT_WIDTH'(1);
                phase_reg     <= tone_now ? phase_adv : phase_eff;
                fade_gain_reg <= tone_now ? fade_adv : fade_eff;
            end
        end
    end

    // ------------------------------------------------------------------
    // Operands of the tick in flight, taken before the state update.
    // ------------------------------------------------------------------
    logic [1:0]                    quad_reg;
    logic [29:0]                   phase_lo_reg;
    logic [crtg_pkg::FADE_W-1:0]   fade_op_reg;
    logic                          tone_reg;
    logic                          last_reg;
    logic [ADDR_W-1:0]             idx_reg;
    logic [crtg_pkg::ROM_W-1:0]    rom_q_reg;
    logic [crtg_pkg::SAMPLE_W-1:0] sample_reg;

    logic [IDX_PROD_W-1:0]         idx_prod;
    logic [ADDR_W-1:0]             idx_raw;
    logic [ADDR_W-1:0]             idx_sel;

    // Table index is the phase within the quadrant scaled to the depth;
    // odd quadrants read the table backwards.
    assign idx_prod = IDX_PROD_W'(phase_lo_reg) * IDX_PROD_W'(SINE_TABLE_DEPTH);
    assign idx_raw  = idx_prod[30 +: ADDR_W];
    assign idx_sel  = quad_reg[0] ? (ADDR_W'(SINE_TABLE_DEPTH - 1) - idx_raw) : idx_raw;

    // ------------------------------------------------------------------
    // Serial multiplier: first ROM value times amplitude, then that product
    // times the fade gain. The magnitude is the product shifted down by 40.
    // ------------------------------------------------------------------
    crtg_pkg::mul_ctrl_t                mul_ctrl;
    crtg_pkg::mul_stat_t                mul_stat;
    logic [crtg_pkg::MCAND_W-1:0]       mul_mcand;
    logic [crtg_pkg::MPLIER_W-1:0]      mul_mplier;
    logic [crtg_pkg::MCAND_W-1:0]       mul_hi;
    logic [crtg_pkg::MPLIER_W-1:0]      mul_lo;
    logic [crtg_pkg::SAMPLE_W-1:0]      mag;

    crtg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mul_ctrl),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .stat    (mul_stat),
        .prod_hi (mul_hi),
        .prod_lo (mul_lo)
    );

    always_comb begin
        mul_ctrl.start = 1'b0;
        mul_ctrl.steps = crtg_pkg::STEPS_AMP;
        mul_mcand      = crtg_pkg::MCAND_W'(rom_q_reg);
        mul_mplier     = crtg_pkg::MPLIER_W'(amplitude_reg);
        if (state_reg == ST_MA_GO) begin
            mul_ctrl.start = 1'b1;
        end else if (state_reg == ST_MA && mul_stat.done) begin
            // The 31-bit first product sits in the low upper bits and the
            // top 16 bits of the shifted-in low register.
            mul_ctrl.start = 1'b1;
            mul_ctrl.steps = crtg_pkg::STEPS_FADE;
            mul_mcand      = {mul_hi[14:0], mul_lo[crtg_pkg::MPLIER_W-1:10]};
            mul_mplier     = crtg_pkg::MPLIER_W'(fade_op_reg);
        end
    end

    // After 13 steps the upper register holds the product shifted by 26.
    assign mag = mul_hi[29:14];

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    logic out_load;

    assign out_load = (state_reg == ST_OUT) && (!m_tvalid || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = tone_now ? ST_IDX : ST_OUT;
                end
            end
            ST_IDX:   state_next = ST_ROM;
            ST_ROM:   state_next = ST_MA_GO;
            ST_MA_GO: state_next = ST_MA;
            ST_MA: begin
                if (mul_stat.done) begin
                    state_next = ST_MB;
                end
            end
            ST_MB: begin
                if (mul_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            quad_reg     <= phase_eff[31:30];
            phase_lo_reg <= phase_eff[29:0];
            fade_op_reg  <= fade_eff;
            tone_reg     <= tone_now;
            last_reg     <= last_now;
            sample_reg   <= '0;
        end
        if (state_reg == ST_IDX) begin
            idx_reg <= idx_sel;
        end
        if (state_reg == ST_ROM) begin
            rom_q_reg <= sine_rom[idx_reg];
        end
        if (state_reg == ST_MB && mul_stat.done) begin
            sample_reg <= quad_reg[1] ? (crtg_pkg::SAMPLE_W'(0) - mag) : mag;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a finished result until it is transferred.
    // ------------------------------------------------------------------
    logic                          m_valid_reg;
    logic [crtg_pkg::SAMPLE_W-1:0] m_sample_reg;
    logic                          m_tone_reg;
    logic                          m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_sample_reg <= sample_reg;
            m_tone_reg   <= tone_reg;
            m_last_reg   <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_sample_reg;
    assign m_tuser  = m_tone_reg;
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("second tick accepted while one is in flight");

    a_cycle_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && last_now) |=> (position_reg == '0 && phase_reg == '0
                                  && fade_gain_reg == '0))
        else $error("cadence state not cleared at cycle end");

    a_fade_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (fade_gain_reg <= crtg_pkg::FADE_ONE))
        else $error("fade gain above one");

    a_mul_in_tone_only: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_stat.busy |-> (state_reg == ST_MA || state_reg == ST_MB))
        else $error("multiplier busy outside the multiply states");

    a_silence_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !tone_reg) |=> (m_tdata == '0))
        else $error("non-zero sample during silence");

endmodule

>>> src/crtg_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Radix-4 shift-and-add multiplier: two multiplier bits per cycle, the low
// product bits shifting into a register beside the running upper part.
// ----------------------------------------------------------------------------
module crtg_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  crtg_pkg::mul_ctrl_t                ctrl,
    input  logic [crtg_pkg::MCAND_W-1:0]       mcand,
    input  logic [crtg_pkg::MPLIER_W-1:0]      mplier,
    output crtg_pkg::mul_stat_t                stat,
    output logic [crtg_pkg::MCAND_W-1:0]       prod_hi,
    output logic [crtg_pkg::MPLIER_W-1:0]      prod_lo
);

    logic                              busy_reg;
    logic                              done_reg;
    logic [crtg_pkg::STEP_W-1:0]       cnt_reg;
    logic [crtg_pkg::MCAND_W-1:0]      mc_reg;
    logic [crtg_pkg::MPLIER_W-1:0]     mp_reg;
    logic [crtg_pkg::MCAND_W-1:0]      hi_reg;
    logic [crtg_pkg::MPLIER_W-1:0]     lo_reg;
    logic [crtg_pkg::MCAND_W+1:0]      addend;
    logic [crtg_pkg::MCAND_W+1:0]      sum;

    // Digit times multiplicand, digit in 0..3; the running upper part stays
    // below 2^31, so the sum fits in 33 bits.
    always_comb begin
        addend = '0;
        if (mp_reg[0]) begin
            addend = addend + {2'b00, mc_reg};
        end
        if (mp_reg[1]) begin
            addend = addend + {1'b0, mc_reg, 1'b0};
        end
        sum = {2'b00, hi_reg} + addend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctrl.steps;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - crtg_pkg::STEP_W'(1);
                if (cnt_reg == crtg_pkg::STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            hi_reg <= '0;
            lo_reg <= '0;
            mc_reg <= mcand;
            mp_reg <= mplier;
        end else if (busy_reg) begin
            hi_reg <= sum[crtg_pkg::MCAND_W+1:2];
            lo_reg <= {sum[1:0], lo_reg[crtg_pkg::MPLIER_W-1:2]};
            mp_reg <= {2'b00, mp_reg[crtg_pkg::MPLIER_W-1:2]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod_hi   = hi_reg;
    assign prod_lo   = lo_reg;

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Cadenced ring tone generator testbench
// Streams sample ticks into the generator, predicts every audio sample, tone
// flag and cycle-end flag in a model of its own, and checks each result
// transfer against the oldest prediction. Register settings change between
// phases while the generator is idle; handshake idling varies per phase.
// ----------------------------------------------------------------------------
module tb;

    localparam int ROM_DEPTH = 1024;
    localparam int MAX_SHOWN = 10;
    localparam int N_PHASES  = 12;
    localparam int PHASE_LEN = 120;
    // An index past the last register; the generator must ignore the write.
    localparam logic [crtg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

    // One result as the generator should produce it.
    typedef struct packed {
        logic [crtg_pkg::SAMPLE_W-1:0] audio;
        logic                          tone;
        logic                          cycle_end;
    } tick_result_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [crtg_pkg::SAMPLE_W-1:0]   m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;
    logic                            cfg_wr_en = 1'b0;
    logic [crtg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [crtg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    cadenced_ring_tone_generator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Register copies held by the predictor, starting at their reset values.
    logic [crtg_pkg::PHASE_W-1:0] step_r      = crtg_pkg::PHASE_STEP_RST;
    logic [crtg_pkg::LEN_W-1:0]   tone_len_r  = crtg_pkg::TONE_LENGTH_RST;
    logic [crtg_pkg::LEN_W-1:0]   cycle_len_r = crtg_pkg::CYCLE_LEN_RST;
    logic [crtg_pkg::AMP_W-1:0]   amp_r       = crtg_pkg::AMPLITUDE_RST;
    logic [crtg_pkg::FADE_W-1:0]  fade_step_r = crtg_pkg::FADE_STEP_RST;

    // Predicted cadence state: position in the cycle, oscillator phase and
    // fade-in gain.
    logic [crtg_pkg::LEN_W-1:0]   pos_q   = '0;
    logic [crtg_pkg::PHASE_W-1:0] phase_q = '0;
    logic [crtg_pkg::FADE_W-1:0]  gain_q  = '0;

    logic [crtg_pkg::ROM_W-1:0]   sine_q15 [ROM_DEPTH];

    bit           tick_queue[$];     // restart flags waiting to be sent
    tick_result_t due_samples[$];    // predicted results not yet received
    idle_mode_t   idle_mode = IDLE_NONE;

    int mismatches = 0;
    int n_ticks    = 0;
    int n_restarts = 0;
    int n_results  = 0;
    int n_tone     = 0;
    int n_ends     = 0;
    int n_settings = 0;

    // The clock runs freely with a period of 20 time units.
    initial begin
        forever #10 aclk = ~aclk;
    end

    // Reset is held low at the start, then released and never asserted again.
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Watchdog: the slowest legal run finishes far inside this window, so
    // reaching it means the generator has hung or lost a transfer.
    initial begin
        #8_000_000;
        $display("Timed out with %0d results outstanding.", due_samples.size());
        $display("== FAIL ==");
        $finish;
    end

    // Quarter-wave sine magnitude for table entry k, taken at the middle of
    // its slot and rounded to Q0.15. A Horner-form Taylor series in Q30 keeps
    // the values exact and repeatable.
    function automatic logic [crtg_pkg::ROM_W-1:0] quarter_sine(input int unsigned k);
        logic [63:0] x, x2, t, s;
        int unsigned dv [6];
        dv = '{156, 110, 72, 42, 20, 6};
        x  = (crtg_pkg::HALF_PI_Q30 * (2 * k + 1)) / (2 * ROM_DEPTH);
        x2 = (x * x) >> 30;
        t  = crtg_pkg::Q30_ONE;
        for (int i = 0; i < 6; i++)
            t = crtg_pkg::Q30_ONE - ((x2 * t) >> 30) / dv[i];
        s = (x * t) >> 30;
        return crtg_pkg::ROM_W'((s * crtg_pkg::SINE_AMP + crtg_pkg::Q30_HALF) >> 30);
    endfunction

    initial begin
        for (int k = 0; k < ROM_DEPTH; k++)
            sine_q15[k] = quarter_sine(k);
    end

    // Advances the cadence by one tick and returns the result it produces.
    // The sample is formed from phase and gain as they stand before the
    // update; phase and gain only move during the tone part.
    function automatic tick_result_t ring_tick(input logic restart);
        tick_result_t res;
        logic [crtg_pkg::LEN_W-1:0] last_pos;
        logic [1:0]                 quad;
        logic [63:0]                addr, mag, gain_sum;
        res = '0;
        if (restart) begin
            pos_q   = '0;
            phase_q = '0;
            gain_q  = '0;
        end
        // A cycle length of zero wraps to the longest possible cycle.
        last_pos      = cycle_len_r - crtg_pkg::LEN_W'(1);
        res.tone      = pos_q < tone_len_r;
        res.cycle_end = pos_q >= last_pos;
        if (res.tone) begin
            quad = phase_q[31:30];
            addr = (64'(phase_q[29:0]) * ROM_DEPTH) >> 30;
            // Odd quadrants run down the table, the lower half-wave negates.
            if (quad[0])
                addr = ROM_DEPTH - 1 - addr;
            mag = (64'(sine_q15[addr]) * 64'(amp_r) * 64'(gain_q)) >> 40;
            res.audio = quad[1] ? -mag[crtg_pkg::SAMPLE_W-1:0] : mag[crtg_pkg::SAMPLE_W-1:0];
            phase_q  = phase_q + step_r;
            gain_sum = 64'(gain_q) + 64'(fade_step_r);
            gain_q   = (gain_sum > 64'(crtg_pkg::FADE_ONE)) ? crtg_pkg::FADE_ONE
                                                            : gain_sum[crtg_pkg::FADE_W-1:0];
        end
        if (res.cycle_end) begin
            pos_q   = '0;
            phase_q = '0;
            gain_q  = '0;
        end else begin
            pos_q = pos_q + crtg_pkg::LEN_W'(1);
        end
        return res;
    endfunction

    function automatic bit roll(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit sender_idle();
        case (idle_mode)
            IDLE_SRC:  return roll(48);
            IDLE_BOTH: return roll(14);
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stall();
        case (idle_mode)
            IDLE_SNK:  return roll(48);
            IDLE_BOTH: return roll(14);
            default:   return 1'b0;
        endcase
    endfunction

    // Driver: presents the next pending tick whenever the channel is free,
    // holding tvalid and tdata steady until the transfer completes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (tick_queue.size() != 0 && !sender_idle()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {7'b0, tick_queue.pop_front()};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, decided afresh on every edge.
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= !receiver_stall();
    end

    // Monitor: checks each result transfer against the oldest prediction,
    // then predicts for any tick accepted on the same edge. A result can
    // never belong to a tick accepted at the same edge, so the order holds.
    always @(posedge aclk) begin
        tick_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_results++;
                n_tone += m_tuser;
                n_ends += m_tlast;
                if (due_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("Result %0d arrived with no tick outstanding: sample %0d",
                                 n_results, $signed(m_tdata));
                end else begin
                    want = due_samples.pop_front();
                    if (m_tdata !== want.audio || m_tuser !== want.tone ||
                        m_tlast !== want.cycle_end) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN) begin
                            $write("Result %0d: expected sample %0d tone %0b end %0b,",
                                   n_results, $signed(want.audio), want.tone,
                                   want.cycle_end);
                            $display(" got sample %0d tone %0b end %0b",
                                     $signed(m_tdata), m_tuser, m_tlast);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                n_ticks++;
                n_restarts += s_tdata[0];
                due_samples.push_back(ring_tick(s_tdata[0]));
            end
        end
    end

    // One register write on the configuration port; the predictor's copy
    // follows at once, which is safe because writes happen only when idle.
    task automatic write_reg(input logic [crtg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [crtg_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            crtg_pkg::REG_PHASE_STEP:  step_r      = val;
            crtg_pkg::REG_TONE_LENGTH: tone_len_r  = val[crtg_pkg::LEN_W-1:0];
            crtg_pkg::REG_CYCLE_LEN:   cycle_len_r = val[crtg_pkg::LEN_W-1:0];
            crtg_pkg::REG_AMPLITUDE:   amp_r       = val[crtg_pkg::AMP_W-1:0];
            crtg_pkg::REG_FADE_STEP:   fade_step_r = val[crtg_pkg::FADE_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_cadence(input logic [31:0] step, input logic [31:0] tone,
                               input logic [31:0] cycle, input logic [31:0] amp,
                               input logic [31:0] fade);
        write_reg(crtg_pkg::REG_PHASE_STEP, step);
        write_reg(crtg_pkg::REG_TONE_LENGTH, tone);
        write_reg(crtg_pkg::REG_CYCLE_LEN, cycle);
        write_reg(crtg_pkg::REG_AMPLITUDE, amp);
        write_reg(crtg_pkg::REG_FADE_STEP, fade);
        n_settings++;
    endtask

    // Holds the sender until every tick has been sent and every predicted
    // result has come back, so the generator is idle afterwards.
    task automatic wait_quiet();
        do @(negedge aclk);
        while (tick_queue.size() != 0 || s_tvalid || due_samples.size() != 0);
    endtask

    // Stimulus: a short directed part, then random phases with a fresh
    // register setting and a fresh idling pattern in each.
    initial begin
        logic [31:0] step, tone, cycle, amp, fade;
        do @(negedge aclk);
        while (!aresetn);

        // Reset settings: plain ticks with a restart in the middle.
        idle_mode = IDLE_NONE;
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b1);
        tick_queue.push_back(1'b0);
        tick_queue.push_back(1'b0);
        wait_quiet();

        // A quarter turn per tick walks every quadrant; the fade step above
        // one saturates the gain after the first tone sample. Six tone
        // samples, two silent ones, then the cycle wraps.
        set_cadence(32'h4000_0000, 6, 8, 32'hFFFF, 32'h1FF_FFFF);
        tick_queue.push_back(1'b1);
        repeat (9) tick_queue.push_back(1'b0);
        wait_quiet();

        // Cycle length zero acts as the longest cycle and the longest tone length
        // makes every tick sent here a tone tick. The unused index is written
        // too and must change nothing.
        set_cadence(32'hFFFF_FFFF, 32'hFF_FFFF, 0, 0, 32'd1 << 20);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        tick_queue.push_back(1'b1);
        repeat (5) tick_queue.push_back(1'b0);
        wait_quiet();

        // Shortening the cycle below the current position ends it at once.
        write_reg(crtg_pkg::REG_CYCLE_LEN, 3);
        write_reg(crtg_pkg::REG_AMPLITUDE, 40000);
        repeat (3) tick_queue.push_back(1'b0);
        wait_quiet();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 0) begin
                // Lowest register values; cycle length one, the shortest cycle.
                step = 0; tone = 0; cycle = 1; amp = 0; fade = 0;
            end else if (p == 1) begin
                // Every register at its highest value.
                step = 32'hFFFF_FFFF; tone = 32'hFF_FFFF; cycle = 32'hFF_FFFF;
                amp = 32'hFFFF; fade = 32'h1FF_FFFF;
            end else begin
                step  = roll(25) ? {2'($urandom_range(3)), 30'd0} : $urandom;
                tone  = roll(12) ? 32'hFF_FFFF : $urandom_range(0, 48);
                cycle = roll(12) ? 0 : roll(12) ? $urandom_range(1, 24'hFF_FFFF)
                                                : $urandom_range(1, 64);
                amp   = roll(12) ? 0 : roll(12) ? 32'hFFFF : $urandom_range(0, 65535);
                fade  = roll(12) ? 0 : roll(12) ? $urandom_range(1 << 24, 32'h1FF_FFFF)
                                                : (1 << 24) / $urandom_range(1, 40);
            end
            set_cadence(step, tone, cycle, amp, fade);
            idle_mode = idle_mode_t'(p % 4);
            for (int i = 0; i < PHASE_LEN; i++) begin
                // Halfway through one phase the sender waits for the
                // generator to drain completely before carrying on.
                if (p == 6 && i == PHASE_LEN / 2)
                    wait_quiet();
                tick_queue.push_back($urandom_range(29) == 0);
            end
            wait_quiet();
        end

        // Allow any stray extra result to show up before the verdict.
        repeat (40) @(negedge aclk);
        $display("Sent %0d ticks (%0d restarts) over %0d register settings.",
                 n_ticks, n_restarts, n_settings);
        $display("Received %0d results: %0d tone samples, %0d cycle ends, %0d mismatches.",
                 n_results, n_tone, n_ends, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
